/* design/b64d_pkg.sv */
// Types, constants and the character decode function for the base64 stream decoder.
// Shared by the front part, the group queue, the back part and the top level.
`timescale 1ns / 1ps

package b64d_pkg;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam logic [5:0] LOWER_BASE  = 6'd26;
    localparam logic [5:0] DIGIT_BASE  = 6'd52;

    // queue depth must be a power of two: pointers wrap by overflow
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [1:0] POS_FOURTH = 2'd3;
    localparam logic [1:0] POS_THIRD  = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_message;
    } char_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
        logic       error;
    } byte_item_t;

    // one finished group or one error, as handed from front to back
    typedef struct packed {
        logic [1:0]  count;
        logic [23:0] triple;
        logic        last;
        logic        error;
    } grp_cmd_t;

    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t s;
        s.bad   = 1'b0;
        s.value = 6'd0;
        if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            s.value = 6'(ch - 8'h41);
        end
        else if (ch >= 8'h61 && ch <= 8'h7A)
        begin
            s.value = 6'(ch - 8'h61) + LOWER_BASE;
        end
        else if (ch >= 8'h30 && ch <= 8'h39)
        begin
            s.value = 6'(ch - 8'h30) + DIGIT_BASE;
        end
        else if (ch == CHAR_PLUS)
        begin
            s.value = SEXTET_PLUS;
        end
        else if (ch == CHAR_SLASH)
        begin
            s.value = SEXTET_SLASH;
        end
        else
        begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

/* design/base64_stream_decoder.sv */
// A group's first byte, or an error, reaches byte_valid through the command queue and
// then the back part's output register after the character that completes it is accepted.
// Throughput: one character per cycle unless the queue is full; the back part sends one
// byte per cycle while byte_ready is high; the four-entry queue absorbs bursts of three bytes.
// Reset: rst_n low clears the group state, the queue and the output valid at once.
`timescale 1ns / 1ps

module base64_stream_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_ready,
    input  b64d_pkg::char_item_t  char_item,
    output logic                  byte_valid,
    input  logic                  byte_ready,
    output b64d_pkg::byte_item_t  byte_item
);

    logic               accept;
    logic               push;
    logic               pop;
    logic               q_not_empty;
    logic               q_full;
    b64d_pkg::grp_cmd_t push_cmd;
    b64d_pkg::grp_cmd_t head_cmd;

    assign char_ready = !q_full;
    assign accept     = char_valid && char_ready;

    b64d_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (char_item),
        .push   (push),
        .cmd    (push_cmd)
    );

    b64d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head      (head_cmd)
    );

    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_not_empty),
        .cmd        (head_cmd),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item)
    );

endmodule

/* design/b64d_front.sv */
// Front part: accepts characters, tracks the group, and emits one queue command
// per finished group or error. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  b64d_pkg::char_item_t   item,
    output logic                   push,
    output b64d_pkg::grp_cmd_t     cmd
);

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] acc_reg, acc_next;
    logic        third_pad_reg, third_pad_next;
    logic        discard_reg, discard_next;

    b64d_pkg::sextet_t s;
    logic              is_pad;
    logic              eom;
    logic              fail;
    logic [5:0]        v;

    always_comb
    begin
        s      = b64d_pkg::sextet_of(item.char_code);
        is_pad = (item.char_code == b64d_pkg::PAD_CHAR);
        eom    = item.end_of_message;
        v      = s.value;
        fail   = 1'b0;

        pos_next       = pos_reg;
        acc_next       = acc_reg;
        third_pad_next = third_pad_reg;
        discard_next   = discard_reg;

        push        = 1'b0;
        cmd.count   = 2'd1;
        cmd.triple  = 24'd0;
        cmd.last    = 1'b1;
        cmd.error   = 1'b0;

        if (accept)
        begin
            if (discard_reg)
            begin
                if (eom)
                begin
                    discard_next   = 1'b0;
                    pos_next       = 2'd0;
                    acc_next       = 18'd0;
                    third_pad_next = 1'b0;
                end
            end
            else if (pos_reg < b64d_pkg::POS_THIRD)
            begin
                if (s.bad || eom)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    acc_next = {acc_reg[11:0], v};
                    pos_next = pos_reg + 2'd1;
                end
            end
            else if (pos_reg == b64d_pkg::POS_THIRD)
            begin
                if (eom)
                begin
                    fail = 1'b1;
                end
                else if (is_pad)
                begin
                    third_pad_next = 1'b1;
                    acc_next       = {acc_reg[11:0], 6'd0};
                    pos_next       = b64d_pkg::POS_FOURTH;
                end
                else if (s.bad)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    acc_next = {acc_reg[11:0], v};
                    pos_next = b64d_pkg::POS_FOURTH;
                end
            end
            else
            begin
                if (is_pad)
                begin
                    if (!eom)
                    begin
                        fail = 1'b1;
                    end
                end
                else if (s.bad || third_pad_reg)
                begin
                    fail = 1'b1;
                end

                if (!fail)
                begin
                    push       = 1'b1;
                    cmd.triple = {acc_reg, (is_pad ? 6'd0 : v)};
                    cmd.last   = eom;
                    cmd.error  = 1'b0;
                    if (is_pad && third_pad_reg)
                    begin
                        cmd.count = 2'd1;
                    end
                    else if (is_pad)
                    begin
                        cmd.count = 2'd2;
                    end
                    else
                    begin
                        cmd.count = 2'd3;
                    end
                    pos_next       = 2'd0;
                    acc_next       = 18'd0;
                    third_pad_next = 1'b0;
                end
            end

            if (fail)
            begin
                push           = 1'b1;
                cmd.count      = 2'd1;
                cmd.triple     = 24'd0;
                cmd.last       = 1'b1;
                cmd.error      = 1'b1;
                pos_next       = 2'd0;
                acc_next       = 18'd0;
                third_pad_next = 1'b0;
                discard_next   = !eom;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            acc_reg       <= 18'd0;
            third_pad_reg <= 1'b0;
            discard_reg   <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            third_pad_reg <= third_pad_next;
            discard_reg   <= discard_next;
        end
    end

endmodule

/* design/b64d_queue.sv */
// Short queue of group commands between the front and back parts.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64d_pkg::grp_cmd_t  push_cmd,
    input  logic                pop,
    output logic                not_empty,
    output logic                full,
    output b64d_pkg::grp_cmd_t  head
);

    b64d_pkg::grp_cmd_t                   slots_reg [b64d_pkg::QUEUE_DEPTH];
    logic [b64d_pkg::QPTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [b64d_pkg::QPTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [b64d_pkg::QCNT_W-1:0]          count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == b64d_pkg::QCNT_W'(b64d_pkg::QUEUE_DEPTH));
    assign head      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/b64d_back.sv */
// Back part: splits each queued command into result items, one a cycle unless
// byte_ready stalls, through an output register. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  b64d_pkg::grp_cmd_t  cmd,
    output logic                pop,
    output logic                byte_valid,
    input  logic                byte_ready,
    output b64d_pkg::byte_item_t byte_item
);

    b64d_pkg::byte_item_t out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           idx_reg, idx_next;
    logic                 load;
    logic                 final_byte;

    assign byte_valid = out_valid_reg;
    assign byte_item  = out_reg;

    always_comb
    begin
        load           = !out_valid_reg || byte_ready;
        final_byte     = (idx_reg == (cmd.count - 2'd1));
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;

        if (load)
        begin
            out_valid_next = cmd_valid;
            if (cmd_valid)
            begin
                case (idx_reg)
                    2'd0:    out_next.data_byte = cmd.triple[23:16];
                    2'd1:    out_next.data_byte = cmd.triple[15:8];
                    default: out_next.data_byte = cmd.triple[7:0];
                endcase
                out_next.is_last = final_byte && cmd.last;
                out_next.error   = cmd.error;
                if (final_byte)
                begin
                    pop      = 1'b1;
                    idx_next = 2'd0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

endmodule

/* design/b64d_checker.sv */
// Port checker for the base64 stream decoder, bound to the top level.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  byte_valid,
    input logic                  byte_ready,
    input b64d_pkg::byte_item_t  byte_item
);

    a_valid_hold : assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> byte_valid)
        else $error("byte_valid dropped before the item was taken");

    a_payload_hold : assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> $stable(byte_item))
        else $error("byte_item changed while stalled");

    a_error_shape : assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_item.error |-> byte_item.is_last && byte_item.data_byte == 8'd0)
        else $error("error item without is_last or with nonzero data");

    a_reset_idle : assert property (@(posedge clk)
        !rst_n |=> !byte_valid)
        else $error("byte_valid high after reset");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item)
);

/* tb/tb_base64_stream_decoder.sv */
// Self-checking testbench for base64_stream_decoder: directed table, then random messages.
// Expected bytes come from typed table rows or an in-bench decoder model; depends on b64d_pkg and the design.
`timescale 1ns / 1ps

module tb_base64_stream_decoder;

    localparam int LIMIT          = 300000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RAND_PER_PHASE = 65;
    localparam int SEND_PCT [3]   = '{16, 50, 0};
    localparam int RECV_PCT [3]   = '{50, 16, 0};
    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;

    typedef struct packed {
        b64d_pkg::char_item_t item;
        logic                 typed;
        logic [1:0]           n;
        logic [23:0]          bytes;
        logic                 last;
        logic                 err;
    } dir_row_t;

    typedef enum int {BREAK_CHAR, BREAK_SHORT, BREAK_PAD, BREAK_NO_END} break_kind_t;

    localparam int NDIR = 27;
    localparam dir_row_t DIR_TAB [NDIR] = '{
        '{'{8'h41, 1'b0}, TYPED, 2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h41, 1'b0}, TYPED, 2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h41, 1'b0}, TYPED, 2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h41, 1'b1}, TYPED, 2'd3, 24'h000000, 1'b1, 1'b0},
        '{'{8'h2F, 1'b0}, TYPED, 2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h2F, 1'b0}, TYPED, 2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h2F, 1'b0}, TYPED, 2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h2F, 1'b0}, TYPED, 2'd3, 24'hFFFFFF, 1'b0, 1'b0},
        '{'{8'h7A, 1'b0}, PRED,  2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h2B, 1'b0}, PRED,  2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h3D, 1'b0}, PRED,  2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h39, 1'b0}, TYPED, 2'd1, 24'h000000, 1'b1, 1'b1},
        '{'{8'h80, 1'b1}, TYPED, 2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h3D, 1'b0}, TYPED, 2'd1, 24'h000000, 1'b1, 1'b1},
        '{'{8'hFF, 1'b1}, TYPED, 2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h51, 1'b0}, PRED,  2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h55, 1'b0}, PRED,  2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h3D, 1'b0}, PRED,  2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h3D, 1'b0}, TYPED, 2'd1, 24'h000000, 1'b1, 1'b1},
        '{'{8'h00, 1'b1}, TYPED, 2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h61, 1'b0}, PRED,  2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h62, 1'b1}, TYPED, 2'd1, 24'h000000, 1'b1, 1'b1},
        '{'{8'h51, 1'b0}, PRED,  2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h55, 1'b0}, PRED,  2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h49, 1'b0}, PRED,  2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'h3D, 1'b1}, PRED,  2'd0, 24'h000000, 1'b0, 1'b0},
        '{'{8'hFF, 1'b1}, TYPED, 2'd1, 24'h000000, 1'b1, 1'b1}
    };

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 char_valid = 1'b0;
    logic                 char_ready;
    b64d_pkg::char_item_t char_item  = '0;
    logic                 byte_valid;
    logic                 byte_ready = 1'b0;
    b64d_pkg::byte_item_t byte_item;

    logic [6:0]  sextet_lut [256];
    logic [1:0]  grp_pos;
    logic [17:0] acc;
    logic        third_pad;
    logic        drop_mode;

    b64d_pkg::byte_item_t expected_bytes [$];
    b64d_pkg::byte_item_t want;
    int         live_items  = 0;
    int         mismatches  = 0;
    int         cycles      = 0;
    int         send_idle   = 0;
    int         recv_idle   = 0;
    int         hold_tokens = 0;
    int         hold_seen   = 0;
    int         hold_cnt    = 0;

    base64_stream_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_base64_stream_decoder NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] b64_char(input int idx);
        if (idx < int'(b64d_pkg::LOWER_BASE))
            return 8'(8'h41 + idx);
        if (idx < int'(b64d_pkg::DIGIT_BASE))
            return 8'(8'h61 + idx - int'(b64d_pkg::LOWER_BASE));
        if (idx < int'(b64d_pkg::SEXTET_PLUS))
            return 8'(8'h30 + idx - int'(b64d_pkg::DIGIT_BASE));
        if (idx == int'(b64d_pkg::SEXTET_PLUS))
            return b64d_pkg::CHAR_PLUS;
        return b64d_pkg::CHAR_SLASH;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[cycle %0d] mismatch: %s", cycles, what);
        mismatches++;
    endtask

    task automatic decode_char(input b64d_pkg::char_item_t it, output int n,
                               output b64d_pkg::byte_item_t [2:0] r);
        logic [6:0]  code;
        logic [5:0]  v;
        logic [23:0] triple;
        logic        ok;
        logic        pad;
        logic        eom;
        logic        err;
        code = sextet_lut[it.char_code];
        ok   = !code[6];
        v    = code[5:0];
        pad  = (it.char_code == b64d_pkg::PAD_CHAR);
        eom  = it.end_of_message;
        err  = 1'b0;
        n    = 0;
        r    = '0;
        if (drop_mode)
        begin
            if (eom)
                drop_mode = 1'b0;
        end
        else if (grp_pos < b64d_pkg::POS_THIRD)
        begin
            if (!ok || eom)
                err = 1'b1;
            else
            begin
                acc = {acc[11:0], v};
                grp_pos++;
            end
        end
        else if (grp_pos == b64d_pkg::POS_THIRD)
        begin
            if (eom || (!pad && !ok))
                err = 1'b1;
            else
            begin
                third_pad = pad;
                acc       = {acc[11:0], pad ? 6'd0 : v};
                grp_pos   = b64d_pkg::POS_FOURTH;
            end
        end
        else
        begin
            if (pad ? !eom : (!ok || third_pad))
                err = 1'b1;
            else
            begin
                triple = {acc, pad ? 6'd0 : v};
                n = pad ? (third_pad ? 1 : 2) : 3;
                for (int i = 0; i < n; i++)
                    r[i] = '{data_byte: 8'(triple >> (16 - 8 * i)),
                             is_last: eom && (i == n - 1), error: 1'b0};
            end
        end
        if (err)
        begin
            r[0]      = '{data_byte: 8'h00, is_last: 1'b1, error: 1'b1};
            n         = 1;
            drop_mode = !eom;
        end
        if (err || n != 0)
        begin
            grp_pos   = 2'd0;
            acc       = '0;
            third_pad = 1'b0;
        end
    endtask

    task automatic send_char(input dir_row_t row);
        int                         n;
        b64d_pkg::byte_item_t [2:0] r;
        if ($urandom_range(99) < send_idle)
        begin
            char_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        char_valid <= 1'b1;
        char_item  <= row.item;
        do @(posedge clk); while (!char_ready);
        if (!drop_mode)
            live_items++;
        decode_char(row.item, n, r);
        if (row.typed)
        begin
            for (int i = 0; i < int'(row.n); i++)
                expected_bytes.push_back('{data_byte: 8'(row.bytes >> (16 - 8 * i)),
                                           is_last: row.last && (i == int'(row.n) - 1),
                                           error: row.err});
        end
        else
        begin
            for (int i = 0; i < n; i++)
                expected_bytes.push_back(r[i]);
        end
    endtask

    task automatic send_message(input int groups, input bit broken);
        b64d_pkg::char_item_t msg [$];
        b64d_pkg::char_item_t it;
        dir_row_t    row;
        break_kind_t kind;
        int          pads;
        int          len;
        int          pos;
        pads = $urandom_range(2);
        len  = groups * 4;
        for (int i = 0; i < len; i++)
        begin
            it.char_code      = b64_char($urandom_range(63));
            it.end_of_message = 1'b0;
            msg.push_back(it);
        end
        if (pads >= 1)
            msg[len - 1].char_code = b64d_pkg::PAD_CHAR;
        if (pads == 2)
            msg[len - 2].char_code = b64d_pkg::PAD_CHAR;
        msg[len - 1].end_of_message = 1'b1;
        if (broken)
        begin
            kind = break_kind_t'($urandom_range(3));
            pos  = $urandom_range(len - 1);
            case (kind)
                BREAK_CHAR:  msg[pos].char_code = 8'($urandom_range(255));
                BREAK_SHORT:
                begin
                    msg = msg[0:pos];
                    msg[pos].end_of_message = 1'b1;
                end
                BREAK_PAD:   msg[pos].char_code = b64d_pkg::PAD_CHAR;
                default:     msg[len - 1].end_of_message = 1'b0;
            endcase
        end
        row = '0;
        row.typed = PRED;
        foreach (msg[i])
        begin
            row.item = msg[i];
            send_char(row);
        end
    endtask

    task automatic drain_results();
        char_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            byte_ready <= 1'b0;
        else
        begin
            if (byte_valid && byte_ready)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch($sformatf("unexpected item byte=%02h last=%0b err=%0b",
                                              byte_item.data_byte, byte_item.is_last,
                                              byte_item.error));
                else
                begin
                    want = expected_bytes.pop_front();
                    if (byte_item.data_byte !== want.data_byte)
                        report_mismatch($sformatf("data_byte %02h, want %02h",
                                                  byte_item.data_byte, want.data_byte));
                    if (byte_item.is_last !== want.is_last)
                        report_mismatch($sformatf("is_last %0b, want %0b",
                                                  byte_item.is_last, want.is_last));
                    if (byte_item.error !== want.error)
                        report_mismatch($sformatf("error %0b, want %0b",
                                                  byte_item.error, want.error));
                end
            end
            if (hold_seen != hold_tokens)
            begin
                hold_seen = hold_tokens;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                byte_ready <= 1'b0;
            end
            else
                byte_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        dir_row_t row;
        int       target;
        int       pick;
        for (int i = 0; i < 256; i++)
            sextet_lut[i] = 7'h40;
        for (int i = 0; i < 64; i++)
            sextet_lut[b64_char(i)] = 7'(i);
        grp_pos   = 2'd0;
        acc       = '0;
        third_pad = 1'b0;
        drop_mode = 1'b0;
        row       = '0;
        row.typed = PRED;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = SEND_PCT[ph];
            recv_idle = RECV_PCT[ph];
            if (ph == 0)
            begin
                foreach (DIR_TAB[i])
                    send_char(DIR_TAB[i]);
                hold_tokens <= hold_tokens + 1;
                send_message(4, 1'b0);
                send_message(4, 1'b0);
                drain_results();
            end
            target = live_items + RAND_PER_PHASE;
            while (live_items < target)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    send_message($urandom_range(1, 4), 1'b0);
                else if (pick < 92)
                    send_message($urandom_range(1, 3), 1'b1);
                else
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        row.item.char_code      = 8'($urandom_range(255));
                        row.item.end_of_message = 1'($urandom_range(1));
                        send_char(row);
                    end
                end
            end
            drain_results();
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_base64_stream_decoder OK");
        else
            $display("tb_base64_stream_decoder NOT OK");
        $finish;
    end

endmodule

/* base64_stream_decoder.f */
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder.sv
design/b64d_checker.sv
tb/tb_base64_stream_decoder.sv
